/* rtl/bfdw_pkg.sv */
// Package for the bidirectional fractional-delay waveguide.
// Holds fixed-point constants, channel payload types and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
package bfdw_pkg;
    localparam int unsigned EXP_FRAC = 16;
    localparam logic [31:0] PERIOD_RESET = 32'd89478;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef struct packed {
        logic [15:0] in_forward;
        logic [15:0] in_backward;
        logic [23:0] delay_samples;
        logic [15:0] loss_factor;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_forward;
        logic [15:0] out_backward;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_INTERP,
        ST_EXP,
        ST_ROOT,
        ST_FRAC_MUL,
        ST_INT_MUL,
        ST_INT_SQ,
        ST_SCALE,
        ST_WRITE,
        ST_OUT
    } state_t;
endpackage

/* rtl/bfdw_if.sv */
// Valid/ready channel interface used by all waveguide ports.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface bfdw_if #(parameter type payload_t = logic [31:0]);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/bfdw_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on nothing; used by the waveguide top level for gain roots.
`timescale 1ns / 1ps
module bfdw_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] radicand,
    output logic        done,
    output logic [30:0] root
);
    logic [61:0] rad_reg, rad_next;
    logic [32:0] rem_reg, rem_next;
    logic [30:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[30:0], rad_reg[61:60]};
        trial     = {root_reg, 2'b01};
        done      = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[59:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[29:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_next;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg) else $error("sqrt busy after done");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("sqrt did not start");
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cnt_reg == 5'd0) else $error("sqrt count not cleared");
endmodule

/* rtl/bidirectional_fractional_delay_waveguide_unit.sv */
// Top level of the bidirectional fractional-delay waveguide.
// Depends on bfdw_pkg, bfdw_if and bfdw_sqrt.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : sink channel, payload {in_forward, in_backward, delay_samples,
//            loss_factor}; one transfer per audio tick.
//   out_ch : source channel, payload {out_forward, out_backward}; exactly
//            one transfer per input transfer, in order.
//   cfg_ch : sink channel carrying sample_period (unsigned Q0.32); write it
//            only while the block is idle.
// Each tick reads both rings at the stored delay with linear interpolation,
// stores the clamped new delay, then writes each input scaled by
// g^(delay * sample_period) into the rings.
// Cost: the gain exponent dominates. Sixteen serial square roots, each followed
// by one multiply, evaluate the fractional exponent bits, and the integer
// exponent bits add a square-and-multiply loop. One item is in flight at a
// time (shared square-root unit, single ring port).
// Reset: a clearing pass writes zero to every ring slot, during which no item
// is accepted (configuration writes still transfer).
// Stall: the result is held in an output register until the receiver takes
// it; a new item is accepted only after that transfer.
module bidirectional_fractional_delay_waveguide_unit
#(
    parameter int DEPTH = 16384
)
(
    input  logic clk,
    input  logic rst_n,
    bfdw_if.sink   in_ch,
    bfdw_if.source out_ch,
    bfdw_if.sink   cfg_ch
);
    localparam int AW = $clog2(DEPTH);
    localparam int FB = 10;
    localparam logic [23:0] D_LO = 24'd1 << FB;
    localparam logic [31:0] D_HI = 32'(DEPTH - 2) << FB;

    // ring memories, one port each shared between read and write
    logic signed [15:0] fwd_mem [DEPTH];
    logic signed [15:0] bwd_mem [DEPTH];

    bfdw_pkg::state_t state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [23:0] delay_reg, delay_next;
    logic [31:0] period_reg;
    logic signed [15:0] sf_reg, sb_reg, fa_reg, ba_reg, fb_reg, bb_reg;
    logic signed [15:0] of_reg, ob_reg;
    logic [23:0] dnew_reg;
    logic [15:0] g_reg;
    logic [31:0] acc_reg, root_reg, base_reg;
    logic [15:0] e_frac_reg;
    logic [13:0] e_int_reg;
    logic [4:0]  j_reg;
    logic        phase_reg;
    logic [55:0] e_prod_reg;
    logic [AW-1:0] addr;
    logic        mem_we;
    logic signed [15:0] wf, wb, rf_reg, rb_reg;
    logic        sq_start, sq_done;
    logic [30:0] sq_root;
    logic [63:0] mul;
    logic signed [47:0] sfm, sbm;
    logic signed [31:0] ipf, ipb;
    logic [AW-1:0] idx;
    logic [FB-1:0] frac;
    logic [23:0] pos;

    assign pos  = delay_reg - D_LO;
    assign idx  = AW'(pos >> FB);
    assign frac = pos[FB-1:0];

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sh7fff;
        if (v < -48'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    bfdw_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({root_reg[31:0], 30'd0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // one 32x32 multiplier, operands picked by state
    always_comb
    begin
        case (state_reg)
            bfdw_pkg::ST_FRAC_MUL: mul = acc_reg * root_reg;
            bfdw_pkg::ST_INT_MUL:  mul = acc_reg * base_reg;
            bfdw_pkg::ST_INT_SQ:   mul = base_reg * base_reg;
            default:               mul = '0;
        endcase
    end

    assign ipf = 32'(fa_reg * $signed({1'b0, (FB+1)'((1 << FB)) - {1'b0, frac}}))
               + 32'(fb_reg * $signed({1'b0, frac}));
    assign ipb = 32'(ba_reg * $signed({1'b0, (FB+1)'((1 << FB)) - {1'b0, frac}}))
               + 32'(bb_reg * $signed({1'b0, frac}));
    assign sfm = 48'(sf_reg * $signed({1'b0, acc_reg[31:15]}));
    assign sbm = 48'(sb_reg * $signed({1'b0, acc_reg[31:15]}));
    assign wf = (state_reg == bfdw_pkg::ST_CLEAR) ? 16'sd0 : sat16(sfm >>> 15);
    assign wb = (state_reg == bfdw_pkg::ST_CLEAR) ? 16'sd0 : sat16(sbm >>> 15);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        clr_next   = clr_reg;
        delay_next = delay_reg;
        addr       = wp_reg;
        mem_we     = 1'b0;
        sq_start   = 1'b0;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        unique case (state_reg)
            bfdw_pkg::ST_CLEAR:
            begin
                addr     = clr_reg;
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = bfdw_pkg::ST_IDLE;
            end
            bfdw_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                addr = wp_reg - AW'(1) - idx;
                if (in_ch.valid)
                    state_next = bfdw_pkg::ST_READ_A;
            end
            bfdw_pkg::ST_READ_A:
            begin
                addr = wp_reg - AW'(2) - idx;
                state_next = bfdw_pkg::ST_READ_B;
            end
            bfdw_pkg::ST_READ_B:  state_next = bfdw_pkg::ST_INTERP;
            bfdw_pkg::ST_INTERP:
            begin
                delay_next = dnew_reg;
                state_next = bfdw_pkg::ST_EXP;
            end
            bfdw_pkg::ST_EXP:
                if (phase_reg)
                begin
                    sq_start = 1'b1;
                    state_next = bfdw_pkg::ST_ROOT;
                end
            bfdw_pkg::ST_ROOT:
                if (sq_done)
                    state_next = bfdw_pkg::ST_FRAC_MUL;
            bfdw_pkg::ST_FRAC_MUL:
                if (j_reg == 5'd16)
                    state_next = bfdw_pkg::ST_INT_MUL;
                else
                begin
                    sq_start = 1'b1;
                    state_next = bfdw_pkg::ST_ROOT;
                end
            bfdw_pkg::ST_INT_MUL:
                state_next = (e_int_reg == '0) ? bfdw_pkg::ST_SCALE : bfdw_pkg::ST_INT_SQ;
            bfdw_pkg::ST_INT_SQ:  state_next = bfdw_pkg::ST_INT_MUL;
            bfdw_pkg::ST_SCALE:   state_next = bfdw_pkg::ST_WRITE;
            bfdw_pkg::ST_WRITE:
            begin
                mem_we  = 1'b1;
                wp_next = wp_reg + 1'b1;
                state_next = bfdw_pkg::ST_OUT;
            end
            bfdw_pkg::ST_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                    state_next = bfdw_pkg::ST_IDLE;
            end
            default: state_next = bfdw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_mem[addr] <= wf;
            bwd_mem[addr] <= wb;
        end
        rf_reg <= fwd_mem[addr];
        rb_reg <= bwd_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bfdw_pkg::ST_CLEAR;
            wp_reg     <= '0;
            clr_reg    <= '0;
            delay_reg  <= D_LO;
            period_reg <= bfdw_pkg::PERIOD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            clr_reg   <= clr_next;
            delay_reg <= delay_next;
            if (cfg_ch.valid)
                period_reg <= cfg_ch.data;
        end
    end

    assign cfg_ch.ready = 1'b1;

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bfdw_pkg::ST_IDLE:
            begin
                sf_reg <= in_ch.data.in_forward;
                sb_reg <= in_ch.data.in_backward;
                g_reg  <= (in_ch.data.loss_factor > 16'd32768) ? 16'd32768
                        : in_ch.data.loss_factor;
                if (in_ch.data.delay_samples < D_LO)      dnew_reg <= D_LO;
                else if (in_ch.data.delay_samples > D_HI) dnew_reg <= D_HI[23:0];
                else dnew_reg <= in_ch.data.delay_samples;
            end
            bfdw_pkg::ST_READ_A:
            begin
                // newer tap arrives from the read issued while idle
                fa_reg <= rf_reg;
                ba_reg <= rb_reg;
            end
            bfdw_pkg::ST_READ_B:
            begin
                fb_reg <= rf_reg;
                bb_reg <= rb_reg;
            end
            bfdw_pkg::ST_INTERP:
            begin
                // interpolate while the stored delay is still the old one
                of_reg <= sat16(48'(ipf >>> FB));
                ob_reg <= sat16(48'(ipb >>> FB));
                phase_reg <= 1'b0;
            end
            bfdw_pkg::ST_EXP:
            begin
                // exponent: delay * period, as two 24x16 halves, low half first
                if (!phase_reg)
                begin
                    e_prod_reg <= 56'(delay_reg * period_reg[15:0]);
                    acc_reg    <= bfdw_pkg::ONE_Q30;
                    root_reg   <= {g_reg, 15'd0};
                    base_reg   <= {g_reg, 15'd0};
                    j_reg      <= 5'd0;
                end
                else
                begin
                    e_frac_reg <= 16'((56'(delay_reg * period_reg[31:16]) + (e_prod_reg >> 16)) >> 10);
                    e_int_reg  <= 14'((56'(delay_reg * period_reg[31:16]) + (e_prod_reg >> 16)) >> 26);
                end
                phase_reg <= 1'b1;
            end
            bfdw_pkg::ST_ROOT:
                if (sq_done)
                begin
                    root_reg <= {1'b0, sq_root};
                    j_reg    <= j_reg + 5'd1;
                end
            bfdw_pkg::ST_FRAC_MUL:
            begin
                if (e_frac_reg[15])
                    acc_reg <= 32'(mul >> 30);
                e_frac_reg <= {e_frac_reg[14:0], 1'b0};
            end
            bfdw_pkg::ST_INT_MUL:
                if (e_int_reg[0])
                    acc_reg <= 32'(mul >> 30);
            bfdw_pkg::ST_INT_SQ:
            begin
                base_reg  <= 32'(mul >> 30);
                e_int_reg <= e_int_reg >> 1;
            end
            default: ;
        endcase
    end

    assign out_ch.data.out_forward  = of_reg;
    assign out_ch.data.out_backward = ob_reg;

    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready) |=> !out_ch.valid)
        else $error("result repeated");
    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfdw_pkg::ST_WRITE |=> wp_reg == $past(wp_reg) + 1'b1)
        else $error("write pointer did not advance");
    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        delay_reg >= D_LO && delay_reg <= D_HI)
        else $error("stored delay out of range");
endmodule
